/* hdl/bmgh_pkg.sv */
// Shared types and constants for the Box-Muller histogram block.
// Holds the sequencer state type, fixed-point constants and divisor tables.
// No dependencies.
`default_nettype none

package bmgh_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_XCALC,
    ST_KL_MUL,
    ST_KH_MUL,
    ST_SQRT_GO,
    ST_ANG_MUL,
    ST_X_GET,
    ST_X_SQ,
    ST_X2_GET,
    ST_T_A,
    ST_T_AP,
    ST_T_DM,
    ST_T_DF,
    ST_T_SV,
    ST_T_SV2,
    ST_SQ_WAIT,
    ST_SC_MUL,
    ST_SC_GET,
    ST_SS_GET,
    ST_FIN
  } state_t;

  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int NBINS = 7;
  localparam logic [2:0] BIN_OUTSIDE = 3'd6;
  localparam logic [2:0] BIN_NONE    = 3'd7;

  localparam logic [31:0] TWO_LN2_Q24 = 32'd23258160;
  localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  // Polynomial step divisors: sine chain first, then cosine chain.
  function automatic logic [6:0] div_of(input logic [2:0] k);
    logic [6:0] d;
    case (k)
      3'd0:    d = 7'd72;
      3'd1:    d = 7'd42;
      3'd2:    d = 7'd20;
      3'd3:    d = 7'd6;
      3'd4:    d = 7'd56;
      3'd5:    d = 7'd30;
      3'd6:    d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] recip_of(input logic [2:0] k);
    logic [31:0] m;
    case (k)
      3'd0:    m = 32'd59652323;
      3'd1:    m = 32'd102261126;
      3'd2:    m = 32'd214748364;
      3'd3:    m = 32'd715827882;
      3'd4:    m = 32'd76695844;
      3'd5:    m = 32'd143165576;
      3'd6:    m = 32'd357913941;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* hdl/box_muller_gaussian_histogram.sv */
// Box-Muller normal pair generator with a seven-bin histogram of the samples.
// The time a draw request takes, from acceptance to result, is set by the one
// shared multiplier, which is used for 32 dependent squarings of the logarithm
// and the sine/cosine polynomial steps, while the bit-serial square root runs
// alongside; a read request goes straight from acceptance to the finish step.
// The block takes one request at a time; a finished result waits in the output
// register and the next request is accepted meanwhile. Uses bmgh_pkg,
// bmgh_mul and bmgh_sqrt.
`default_nettype none

module box_muller_gaussian_histogram
  import bmgh_pkg::*;
#(
  parameter int SAMPLE_FRAC_BITS = 12,
  parameter int COUNT_WIDTH      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic [31:0]        in_first_uniform,
  input  wire logic [31:0]        in_second_uniform,
  input  wire logic [2:0]         in_bin_select,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_normal_cos,
  output logic signed [15:0]      out_normal_sin,
  output logic [2:0]              out_bin_cos,
  output logic [2:0]              out_bin_sin,
  output logic [31:0]             out_count_value
);

  localparam int SH = 54 - SAMPLE_FRAC_BITS;
  localparam int ZW = SAMPLE_FRAC_BITS + 18;
  localparam logic signed [ZW-1:0] OFF = ZW'(3) << SAMPLE_FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t state_r, state_nxt;

  logic        func_r, func_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic [31:0] code_r, code_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [31:0] y_r, y_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [37:0] x_r, x_nxt;
  logic [24:0] acc_r, acc_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [29:0] xa_r, xa_nxt;
  logic [29:0] x2_r, x2_nxt;
  logic [29:0] a_r, a_nxt;
  logic [30:0] t_r, t_nxt;
  logic [30:0] sv_r, sv_nxt;
  logic [30:0] cv_r, cv_nxt;
  logic signed [15:0] zc_r, zc_nxt;
  logic signed [15:0] zs_r, zs_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic signed [15:0] out_cos_r, out_cos_nxt;
  logic signed [15:0] out_sin_r, out_sin_nxt;
  logic [2:0]  out_bc_r, out_bc_nxt;
  logic [2:0]  out_bs_r, out_bs_nxt;
  logic [31:0] out_cnt_r, out_cnt_nxt;

  logic [COUNT_WIDTH-1:0] cnt_r [NBINS];
  logic                   bump;

  logic [31:0] op_a, op_b;
  logic [63:0] prod_r;
  logic        sq_start, sq_busy;
  logic [26:0] sq_root;
  logic [29:0] lsum;

  logic [5:0]  nsh;
  logic [31:0] ntop;
  logic [32:0] sq_s;
  logic [30:0] f_full;
  logic [29:0] fval;
  logic [29:0] q0;
  logic [6:0]  dv;
  logic [36:0] qd;
  logic [36:0] rmd;
  logic [29:0] qv;
  logic [30:0] tn;
  logic        swap;
  logic [30:0] cc, ss, cm, sm;
  logic        cn, sn;
  logic [2:0]  bc, bs;
  logic [COUNT_WIDTH-1:0] rd;
  logic [31:0] rd32;
  logic        load_out;

  function automatic logic signed [15:0] make_sample(input logic [63:0] pr,
                                                     input logic neg);
    logic [63:0] v;
    logic [16:0] m;
    v = (pr + (64'd1 << (SH - 1))) >> SH;
    if (neg) begin
      m = (v > 64'd32768) ? 17'd32768 : v[16:0];
      m = 17'd0 - m;
    end else begin
      m = (v > 64'd32767) ? 17'd32767 : v[16:0];
    end
    return m[15:0];
  endfunction

  function automatic logic [2:0] bin_of(input logic signed [15:0] z);
    logic signed [ZW-1:0] zx;
    logic [ZW-1:0]        sum;
    logic [ZW-1:0]        idx;
    zx  = {{(ZW-16){z[15]}}, z};
    sum = zx + OFF;
    idx = sum >> SAMPLE_FRAC_BITS;
    if (zx < -OFF || zx >= OFF) begin
      return BIN_OUTSIDE;
    end
    return idx[2:0];
  endfunction

  bmgh_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign lsum     = prod_r[29:0] + {5'b0, acc_r};
  assign sq_start = (state_r == ST_SQRT_GO);

  bmgh_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({lsum, 24'b0}),
    .busy_r   (sq_busy),
    .root     (sq_root)
  );

  // angle reduction, quadrant mapping, constant division correction, normalization shift, bin lookup and count readout
  always_comb begin
    swap   = phase_r[29];
    f_full = {1'b1, 30'b0} - {1'b0, phase_r[29:0]};
    fval   = swap ? f_full[29:0] : phase_r[29:0];
    cc     = swap ? sv_r : cv_r;
    ss     = swap ? cv_r : sv_r;
    case (phase_r[31:30])
      2'd0:    begin cm = cc; cn = 1'b0; sm = ss; sn = 1'b0; end
      2'd1:    begin cm = ss; cn = 1'b1; sm = cc; sn = 1'b0; end
      2'd2:    begin cm = cc; cn = 1'b1; sm = ss; sn = 1'b1; end
      default: begin cm = ss; cn = 1'b0; sm = cc; sn = 1'b1; end
    endcase
    dv  = div_of(k_r[2:0]);
    q0  = prod_r[61:32];
    qd  = 37'(q0) * 37'(dv);
    rmd = {7'b0, a_r} - qd;
    qv  = (rmd >= 37'(dv)) ? q0 + 30'd1 : q0;
    tn  = Q30_ONE - {1'b0, qv};
    nsh  = 6'd16 >> k_r;
    ntop = code_r >> (6'd32 - nsh);
    sq_s = prod_r[63:31];
    bc   = bin_of(zc_r);
    bs   = bin_of(zs_r);
    rd   = (sel_r == BIN_NONE) ? '0 : cnt_r[sel_r];
    if (COUNT_WIDTH > 32 && (rd >> 32) != '0) begin
      rd32 = 32'hFFFF_FFFF;
    end else begin
      rd32 = 32'(rd);
    end
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_LOG_MUL: begin op_a = code_r; op_b = code_r; end
      ST_KL_MUL:  begin op_a = x_r[31:0]; op_b = TWO_LN2_Q24; end
      ST_KH_MUL:  begin op_a = {26'b0, x_r[37:32]}; op_b = TWO_LN2_Q24; end
      ST_ANG_MUL: begin op_a = {2'b0, fval}; op_b = TWO_PI_Q29; end
      ST_X_SQ:    begin op_a = {2'b0, xa_r}; op_b = {2'b0, xa_r}; end
      ST_T_A:     begin op_a = {2'b0, x2_r}; op_b = {1'b0, t_r}; end
      ST_T_DM:    begin op_a = {2'b0, a_r}; op_b = recip_of(k_r[2:0]); end
      ST_T_SV:    begin op_a = {2'b0, xa_r}; op_b = {1'b0, t_r}; end
      ST_SC_MUL:  begin op_a = {5'b0, sq_root}; op_b = {1'b0, cm}; end
      ST_SC_GET:  begin op_a = {5'b0, sq_root}; op_b = {1'b0, sm}; end
      default:    begin op_a = '0; op_b = '0; end
    endcase
  end

  assign load_out = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign bump     = load_out && (func_r == FUNC_DRAW);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    sel_nxt       = sel_r;
    code_nxt      = code_r;
    p_nxt         = p_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    xa_nxt        = xa_r;
    x2_nxt        = x2_r;
    a_nxt         = a_r;
    t_nxt         = t_r;
    sv_nxt        = sv_r;
    cv_nxt        = cv_r;
    zc_nxt        = zc_r;
    zs_nxt        = zs_r;
    out_valid_nxt = out_valid_r;
    out_cos_nxt   = out_cos_r;
    out_sin_nxt   = out_sin_r;
    out_bc_nxt    = out_bc_r;
    out_bs_nxt    = out_bs_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          sel_nxt   = in_bin_select;
          code_nxt  = (in_first_uniform == 32'd0) ? 32'd1 : in_first_uniform;
          phase_nxt = in_second_uniform;
          p_nxt     = 5'd31;
          y_nxt     = '0;
          k_nxt     = '0;
          state_nxt = (in_func == FUNC_READ) ? ST_FIN : ST_NORM;
        end
      end
      ST_NORM: begin
        if (ntop == 32'd0) begin
          code_nxt = code_r << nsh;
          p_nxt    = p_r - nsh[4:0];
        end
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd4) begin
          k_nxt     = '0;
          state_nxt = ST_LOG_MUL;
        end
      end
      ST_LOG_MUL: state_nxt = ST_LOG_UPD;
      ST_LOG_UPD: begin
        if (sq_s[32]) begin
          code_nxt = sq_s[32:1];
          y_nxt    = y_r | (32'h8000_0000 >> k_r);
        end else begin
          code_nxt = sq_s[31:0];
        end
        k_nxt     = k_r + 5'd1;
        state_nxt = (k_r == 5'd31) ? ST_XCALC : ST_LOG_MUL;
      end
      ST_XCALC: begin
        x_nxt     = {6'd32 - {1'b0, p_r}, 32'b0} - {6'b0, y_r};
        state_nxt = ST_KL_MUL;
      end
      ST_KL_MUL: state_nxt = ST_KH_MUL;
      ST_KH_MUL: begin
        acc_nxt   = prod_r[56:32];
        state_nxt = ST_SQRT_GO;
      end
      ST_SQRT_GO: state_nxt = ST_ANG_MUL;
      ST_ANG_MUL: state_nxt = ST_X_GET;
      ST_X_GET: begin
        xa_nxt    = prod_r[60:31];
        state_nxt = ST_X_SQ;
      end
      ST_X_SQ: state_nxt = ST_X2_GET;
      ST_X2_GET: begin
        x2_nxt    = prod_r[59:30];
        k_nxt     = '0;
        state_nxt = ST_T_A;
      end
      ST_T_A: begin
        if (k_r == 5'd0 || k_r == 5'd4) begin
          a_nxt     = x2_r;
          state_nxt = ST_T_DM;
        end else begin
          state_nxt = ST_T_AP;
        end
      end
      ST_T_AP: begin
        a_nxt     = prod_r[59:30];
        state_nxt = ST_T_DM;
      end
      ST_T_DM: state_nxt = ST_T_DF;
      ST_T_DF: begin
        t_nxt = tn;
        if (k_r == 5'd3) begin
          state_nxt = ST_T_SV;
        end else if (k_r == 5'd7) begin
          cv_nxt    = tn;
          state_nxt = ST_SQ_WAIT;
        end else begin
          k_nxt     = k_r + 5'd1;
          state_nxt = ST_T_A;
        end
      end
      ST_T_SV: state_nxt = ST_T_SV2;
      ST_T_SV2: begin
        sv_nxt    = prod_r[60:30];
        k_nxt     = 5'd4;
        state_nxt = ST_T_A;
      end
      ST_SQ_WAIT: begin
        if (!sq_busy) begin
          state_nxt = ST_SC_MUL;
        end
      end
      ST_SC_MUL: state_nxt = ST_SC_GET;
      ST_SC_GET: begin
        zc_nxt    = make_sample(prod_r, cn);
        state_nxt = ST_SS_GET;
      end
      ST_SS_GET: begin
        zs_nxt    = make_sample(prod_r, sn);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (func_r == FUNC_READ) begin
            out_cos_nxt = '0;
            out_sin_nxt = '0;
            out_bc_nxt  = '0;
            out_bs_nxt  = '0;
            out_cnt_nxt = rd32;
          end else begin
            out_cos_nxt = zc_r;
            out_sin_nxt = zs_r;
            out_bc_nxt  = bc;
            out_bs_nxt  = bs;
            out_cnt_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    sel_r     <= sel_nxt;
    code_r    <= code_nxt;
    p_r       <= p_nxt;
    y_r       <= y_nxt;
    k_r       <= k_nxt;
    x_r       <= x_nxt;
    acc_r     <= acc_nxt;
    phase_r   <= phase_nxt;
    xa_r      <= xa_nxt;
    x2_r      <= x2_nxt;
    a_r       <= a_nxt;
    t_r       <= t_nxt;
    sv_r      <= sv_nxt;
    cv_r      <= cv_nxt;
    zc_r      <= zc_nxt;
    zs_r      <= zs_nxt;
    out_cos_r <= out_cos_nxt;
    out_sin_r <= out_sin_nxt;
    out_bc_r  <= out_bc_nxt;
    out_bs_r  <= out_bs_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // saturating bin counters, two hits possible per draw
  always_ff @(posedge clk) begin
    logic [1:0]           inc;
    logic [COUNT_WIDTH:0] sum;
    for (int i = 0; i < NBINS; i++) begin
      inc = {1'b0, (bc == 3'(i))} + {1'b0, (bs == 3'(i))};
      sum = {1'b0, cnt_r[i]} + (COUNT_WIDTH+1)'(inc);
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else if (bump) begin
        cnt_r[i] <= (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[COUNT_WIDTH-1:0];
      end
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_normal_cos  = out_cos_r;
  assign out_normal_sin  = out_sin_r;
  assign out_bin_cos     = out_bc_r;
  assign out_bin_sin     = out_bs_r;
  assign out_count_value = out_cnt_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted request did not start work");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside the finish step");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r[0] >= $past(cnt_r[0])))
    else $error("bin counter decreased");

  a_count_only_on_draw: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r[6] != $past(cnt_r[6])))
      |-> $past(state_r == ST_FIN && func_r == FUNC_DRAW))
    else $error("bin counter changed outside a draw completion");

  a_sqrt_done_before_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SC_MUL) |-> !sq_busy)
    else $error("radius used before square root finished");

endmodule

`default_nettype wire

/* hdl/bmgh_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
// Used by the sequencer for every product but the quotient check; depends on nothing.
`default_nettype none

module bmgh_mul (
  input  wire logic        clk,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic      [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

endmodule

`default_nettype wire

/* hdl/bmgh_sqrt.sv */
// Bit-serial integer square root of a 54-bit radicand, one result bit a cycle.
// Depends on nothing; started and polled by the top-level sequencer.
`default_nettype none

module bmgh_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [53:0] radicand,
  output logic             busy_r,
  output logic      [26:0] root
);

  logic [55:0] rem_r, rem_nxt;
  logic [55:0] root_r, root_nxt;
  logic [4:0]  k_r, k_nxt;
  logic        busy_nxt;
  logic [55:0] bitv;
  logic [56:0] trial;

  always_comb begin
    bitv     = 56'd1 << {k_r, 1'b0};
    trial    = {1'b0, root_r} + {1'b0, bitv};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = {2'b00, radicand};
      root_nxt = '0;
      k_nxt    = 5'd26;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt  = rem_r - trial[55:0];
        root_nxt = (root_r >> 1) + bitv;
      end else begin
        root_nxt = root_r >> 1;
      end
      k_nxt = k_r - 5'd1;
      if (k_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    k_r    <= k_nxt;
  end

  assign root = root_r[26:0];

endmodule

`default_nettype wire
